>>> hw/rtl/pinhole_pixel_to_ray_assert.svh
// Assertion macros for the pixel-to-ray block.
// Uses aclk and aresetn of the module that includes it.
`ifndef PINHOLE_PIXEL_TO_RAY_ASSERT_SVH
`define PINHOLE_PIXEL_TO_RAY_ASSERT_SVH

// same-cycle implication
`define PPR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pixel_to_ray check failed");

// next-cycle implication
`define PPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pixel_to_ray check failed");

`endif

>>> hw/rtl/ppr_pkg.sv
// Shared constants for the pixel-to-ray block.
// No dependencies.
`default_nettype none
package ppr_pkg;
    localparam int PIXEL_BITS_DEF = 16;
    localparam int OFS_W          = 24;  // quotient bits of the offset divider
    localparam int MAG_W          = 24;  // magnitude of a Q8.16 offset
    localparam int SQ_W           = 48;  // sum of squares, Q.32
    localparam int ROOT_W         = 24;  // square root, Q.16
    localparam int CN_W           = 40;  // component numerator
    localparam int CQ_W           = 17;  // component quotient bits
    localparam int DIR_W          = 16;
    localparam int DIRZ_W         = 15;
    localparam int CFG_IDX_W      = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRINCIPAL_X = 2'd0,
        REG_PRINCIPAL_Y = 2'd1,
        REG_FOCAL_X     = 2'd2,
        REG_FOCAL_Y     = 2'd3
    } cfg_reg_t;
endpackage
`default_nettype wire

>>> hw/rtl/pinhole_pixel_to_ray.sv
// Pinhole back-projection: Q12.4 pixel pair in, Q1.15 unit ray out.
// Stages in order: difference, numerator, offset divider, saturate, squares, sum, root, numerators, dividers, output.
// Throughput: one item per clock; the whole pipe advances together and halts
// only while a finished item waits at the output register.
// Reset (aresetn low, synchronous): valid bits cleared, registers to 0/0/1.0/1.0.
// Depends on ppr_pkg and pinhole_pixel_to_ray_assert.svh.
`default_nettype none
module pinhole_pixel_to_ray #(
    parameter int PIXEL_BITS = ppr_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // item in
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [((2*PIXEL_BITS+7)/8)*8-1:0] s_tdata, // pixel_x, pixel_y, zero pad
    // item out
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [47:0]                       m_tdata,  // dir_x, dir_y, dir_z, zero pad
    output logic [0:0]                        m_tuser,  // clipped
    // register writes
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [ppr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PIXEL_BITS-1:0]        cfg_data
);
    import ppr_pkg::*;

    localparam int P     = PIXEL_BITS;
    localparam int NUM_W = P + 17;           // (d << 16) + f/2

    // ---------------- configuration ----------------
    logic [P-1:0] cx_reg, cy_reg, fx_reg, fy_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg <= '0;
            cy_reg <= '0;
            fx_reg <= P'(16);
            fy_reg <= P'(16);
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_PRINCIPAL_X: cx_reg <= cfg_data;
                REG_PRINCIPAL_Y: cy_reg <= cfg_data;
                REG_FOCAL_X:     fx_reg <= cfg_data;
                REG_FOCAL_Y:     fy_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // whole pipe moves when the output slot is free or being taken
    logic pipe_en;
    assign pipe_en  = !m_tvalid || m_tready;
    assign s_tready = pipe_en;

    // ---------------- stage 1: difference and sign ----------------
    logic [P-1:0] pix   [2];
    logic [P-1:0] cen   [2];
    logic [P-1:0] foc   [2];
    logic         v1_reg;
    logic [P-1:0] d1_reg [2];
    logic [P-1:0] f1_reg [2];
    logic         n1_reg [2];

    always_comb begin
        pix[0] = s_tdata[P-1:0];
        pix[1] = s_tdata[2*P-1:P];
        cen[0] = cx_reg;
        cen[1] = cy_reg;
        // a focal length of zero acts as one sixteenth of a pixel
        foc[0] = (fx_reg == '0) ? P'(1) : fx_reg;
        foc[1] = (fy_reg == '0) ? P'(1) : fy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int a = 0; a < 2; a++) begin
                n1_reg[a] <= pix[a] < cen[a];
                d1_reg[a] <= (pix[a] < cen[a]) ? cen[a] - pix[a] : pix[a] - cen[a];
                f1_reg[a] <= foc[a];
            end
        end
    end

    // ---------------- stage 2: rounded numerator ----------------
    logic             v2_reg;
    logic [NUM_W-1:0] num2_reg [2];
    logic [P-1:0]     f2_reg   [2];
    logic             n2_reg   [2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (pipe_en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int a = 0; a < 2; a++) begin
                num2_reg[a] <= {1'b0, d1_reg[a], 16'h0000} + NUM_W'(f1_reg[a][P-1:1]);
                f2_reg[a]   <= f1_reg[a];
                n2_reg[a]   <= n1_reg[a];
            end
        end
    end

    // ---------------- offset divider: one quotient bit per stage ----------------
    logic             dv_vld_reg [OFS_W+1];
    logic [P-1:0]     dv_rem_reg [2][OFS_W+1];
    logic [OFS_W-1:0] dv_low_reg [2][OFS_W+1];
    logic [OFS_W-1:0] dv_q_reg   [2][OFS_W+1];
    logic [P-1:0]     dv_f_reg   [2][OFS_W+1];
    logic             dv_n_reg   [2][OFS_W+1];
    logic             dv_ovf_reg [2][OFS_W+1];

    logic [P:0]       dv_t    [2][OFS_W];
    logic             dv_ge   [2][OFS_W];
    logic [P:0]       dv_diff [2][OFS_W];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            for (int k = 0; k < OFS_W; k++) begin
                dv_t[a][k]    = {dv_rem_reg[a][k], dv_low_reg[a][k][OFS_W-1]};
                dv_ge[a][k]   = dv_t[a][k] >= {1'b0, dv_f_reg[a][k]};
                dv_diff[a][k] = dv_t[a][k] - {1'b0, dv_f_reg[a][k]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= OFS_W; k++) dv_vld_reg[k] <= 1'b0;
        end else if (pipe_en) begin
            dv_vld_reg[0] <= v2_reg;
            for (int k = 1; k <= OFS_W; k++) dv_vld_reg[k] <= dv_vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int a = 0; a < 2; a++) begin
                dv_rem_reg[a][0] <= P'(num2_reg[a][NUM_W-1:OFS_W]);
                dv_low_reg[a][0] <= num2_reg[a][OFS_W-1:0];
                dv_q_reg[a][0]   <= '0;
                dv_f_reg[a][0]   <= f2_reg[a];
                dv_n_reg[a][0]   <= n2_reg[a];
                // quotient of 2^24 or more saturates either way
                dv_ovf_reg[a][0] <= P'(num2_reg[a][NUM_W-1:OFS_W]) >= f2_reg[a];
                for (int k = 1; k <= OFS_W; k++) begin
                    dv_rem_reg[a][k] <= dv_ge[a][k-1] ? dv_diff[a][k-1][P-1:0]
                                                      : dv_t[a][k-1][P-1:0];
                    dv_low_reg[a][k] <= {dv_low_reg[a][k-1][OFS_W-2:0], 1'b0};
                    dv_q_reg[a][k]   <= {dv_q_reg[a][k-1][OFS_W-2:0], dv_ge[a][k-1]};
                    dv_f_reg[a][k]   <= dv_f_reg[a][k-1];
                    dv_n_reg[a][k]   <= dv_n_reg[a][k-1];
                    dv_ovf_reg[a][k] <= dv_ovf_reg[a][k-1];
                end
            end
        end
    end

    // ---------------- stage 3: saturate offsets to Q8.16 ----------------
    logic             v3_reg;
    logic [MAG_W-1:0] mag3_reg [2];
    logic             n3_reg   [2];
    logic             clip3_reg;
    logic [MAG_W-1:0] sat_mag  [2];
    logic             sat_clip [2];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            if (dv_n_reg[a][OFS_W]) begin
                sat_clip[a] = dv_ovf_reg[a][OFS_W] ||
                              (dv_q_reg[a][OFS_W] > MAG_W'(24'h80_0000));
                sat_mag[a]  = sat_clip[a] ? MAG_W'(24'h80_0000) : dv_q_reg[a][OFS_W];
            end else begin
                sat_clip[a] = dv_ovf_reg[a][OFS_W] ||
                              (dv_q_reg[a][OFS_W] > MAG_W'(24'h7F_FFFF));
                sat_mag[a]  = sat_clip[a] ? MAG_W'(24'h7F_FFFF) : dv_q_reg[a][OFS_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (pipe_en) begin
            v3_reg <= dv_vld_reg[OFS_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int a = 0; a < 2; a++) begin
                mag3_reg[a] <= sat_mag[a];
                n3_reg[a]   <= dv_n_reg[a][OFS_W] && (sat_mag[a] != '0);
            end
            clip3_reg <= sat_clip[0] || sat_clip[1];
        end
    end

    // ---------------- stage 4: squares; stage 5: sum ----------------
    logic             v4_reg, v5_reg;
    logic [SQ_W-1:0]  sq4_reg  [2];
    logic [MAG_W-1:0] mag4_reg [2];
    logic [MAG_W-1:0] mag5_reg [2];
    logic             n4_reg   [2];
    logic             n5_reg   [2];
    logic             clip4_reg, clip5_reg;
    logic [SQ_W-1:0]  sum5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (pipe_en) begin
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int a = 0; a < 2; a++) begin
                sq4_reg[a]  <= SQ_W'(mag3_reg[a]) * SQ_W'(mag3_reg[a]);
                mag4_reg[a] <= mag3_reg[a];
                n4_reg[a]   <= n3_reg[a];
                mag5_reg[a] <= mag4_reg[a];
                n5_reg[a]   <= n4_reg[a];
            end
            clip4_reg <= clip3_reg;
            clip5_reg <= clip4_reg;
            // the z term is 1.0 squared in Q.32
            sum5_reg  <= sq4_reg[0] + sq4_reg[1] + (SQ_W'(1) << 32);
        end
    end

    // ---------------- square root: one result bit per stage ----------------
    logic             sq_vld_reg  [ROOT_W+1];
    logic [ROOT_W:0]  sq_rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root_reg [ROOT_W+1];
    logic [SQ_W-1:0]  sq_s_reg    [ROOT_W+1];
    logic [MAG_W-1:0] sq_mag_reg  [2][ROOT_W+1];
    logic             sq_n_reg    [2][ROOT_W+1];
    logic             sq_clip_reg [ROOT_W+1];

    logic [ROOT_W+2:0] sq_t     [ROOT_W];
    logic [ROOT_W+2:0] sq_trial [ROOT_W];
    logic              sq_ge    [ROOT_W];
    logic [ROOT_W+2:0] sq_diff  [ROOT_W];

    always_comb begin
        for (int j = 0; j < ROOT_W; j++) begin
            sq_t[j]     = {sq_rem_reg[j], sq_s_reg[j][SQ_W-1:SQ_W-2]};
            sq_trial[j] = {1'b0, sq_root_reg[j], 2'b01};
            sq_ge[j]    = sq_t[j] >= sq_trial[j];
            sq_diff[j]  = sq_t[j] - sq_trial[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= ROOT_W; j++) sq_vld_reg[j] <= 1'b0;
        end else if (pipe_en) begin
            sq_vld_reg[0] <= v5_reg;
            for (int j = 1; j <= ROOT_W; j++) sq_vld_reg[j] <= sq_vld_reg[j-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_s_reg[0]    <= sum5_reg;
            sq_clip_reg[0] <= clip5_reg;
            for (int a = 0; a < 2; a++) begin
                sq_mag_reg[a][0] <= mag5_reg[a];
                sq_n_reg[a][0]   <= n5_reg[a];
            end
            for (int j = 1; j <= ROOT_W; j++) begin
                // remainder stays within twice the partial root
                sq_rem_reg[j]  <= sq_ge[j-1] ? sq_diff[j-1][ROOT_W:0] : sq_t[j-1][ROOT_W:0];
                sq_root_reg[j] <= {sq_root_reg[j-1][ROOT_W-2:0], sq_ge[j-1]};
                sq_s_reg[j]    <= {sq_s_reg[j-1][SQ_W-3:0], 2'b00};
                sq_clip_reg[j] <= sq_clip_reg[j-1];
                for (int a = 0; a < 2; a++) begin
                    sq_mag_reg[a][j] <= sq_mag_reg[a][j-1];
                    sq_n_reg[a][j]   <= sq_n_reg[a][j-1];
                end
            end
        end
    end

    // ---------------- stage 6: component numerators ----------------
    // lanes 0 and 1 are x and y, lane 2 is z (magnitude 1.0)
    logic              v6_reg;
    logic [CN_W-1:0]   cn6_reg [3];
    logic [ROOT_W-1:0] r6_reg;
    logic              n6_reg  [2];
    logic              clip6_reg;
    logic [ROOT_W-1:0] root_fin;

    assign root_fin = sq_root_reg[ROOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (pipe_en) begin
            v6_reg <= sq_vld_reg[ROOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int a = 0; a < 2; a++) begin
                cn6_reg[a] <= CN_W'({sq_mag_reg[a][ROOT_W], 15'h0000})
                            + CN_W'(root_fin[ROOT_W-1:1]);
                n6_reg[a]  <= sq_n_reg[a][ROOT_W];
            end
            cn6_reg[2] <= (CN_W'(1) << 31) + CN_W'(root_fin[ROOT_W-1:1]);
            r6_reg     <= root_fin;
            clip6_reg  <= sq_clip_reg[ROOT_W];
        end
    end

    // ---------------- component dividers, three lanes ----------------
    logic              cd_vld_reg  [CQ_W+1];
    logic [ROOT_W-1:0] cd_rem_reg  [3][CQ_W+1];
    logic [CQ_W-1:0]   cd_low_reg  [3][CQ_W+1];
    logic [CQ_W-1:0]   cd_q_reg    [3][CQ_W+1];
    logic              cd_ovf_reg  [3][CQ_W+1];
    logic [ROOT_W-1:0] cd_r_reg    [CQ_W+1];
    logic              cd_n_reg    [2][CQ_W+1];
    logic              cd_clip_reg [CQ_W+1];

    logic [ROOT_W:0]   cd_t    [3][CQ_W];
    logic              cd_ge   [3][CQ_W];
    logic [ROOT_W:0]   cd_diff [3][CQ_W];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < CQ_W; k++) begin
                cd_t[c][k]    = {cd_rem_reg[c][k], cd_low_reg[c][k][CQ_W-1]};
                cd_ge[c][k]   = cd_t[c][k] >= {1'b0, cd_r_reg[k]};
                cd_diff[c][k] = cd_t[c][k] - {1'b0, cd_r_reg[k]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= CQ_W; k++) cd_vld_reg[k] <= 1'b0;
        end else if (pipe_en) begin
            cd_vld_reg[0] <= v6_reg;
            for (int k = 1; k <= CQ_W; k++) cd_vld_reg[k] <= cd_vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            cd_r_reg[0]    <= r6_reg;
            cd_clip_reg[0] <= clip6_reg;
            for (int a = 0; a < 2; a++) cd_n_reg[a][0] <= n6_reg[a];
            for (int c = 0; c < 3; c++) begin
                cd_rem_reg[c][0] <= ROOT_W'(cn6_reg[c][CN_W-1:CQ_W]);
                cd_low_reg[c][0] <= cn6_reg[c][CQ_W-1:0];
                cd_q_reg[c][0]   <= '0;
                cd_ovf_reg[c][0] <= ROOT_W'(cn6_reg[c][CN_W-1:CQ_W]) >= r6_reg;
            end
            for (int k = 1; k <= CQ_W; k++) begin
                cd_r_reg[k]    <= cd_r_reg[k-1];
                cd_clip_reg[k] <= cd_clip_reg[k-1];
                for (int a = 0; a < 2; a++) cd_n_reg[a][k] <= cd_n_reg[a][k-1];
                for (int c = 0; c < 3; c++) begin
                    cd_rem_reg[c][k] <= cd_ge[c][k-1] ? cd_diff[c][k-1][ROOT_W-1:0]
                                                      : cd_t[c][k-1][ROOT_W-1:0];
                    cd_low_reg[c][k] <= {cd_low_reg[c][k-1][CQ_W-2:0], 1'b0};
                    cd_q_reg[c][k]   <= {cd_q_reg[c][k-1][CQ_W-2:0], cd_ge[c][k-1]};
                    cd_ovf_reg[c][k] <= cd_ovf_reg[c][k-1];
                end
            end
        end
    end

    // ---------------- output register: saturate and sign ----------------
    logic              out_vld_reg;
    logic [DIR_W-1:0]  out_dx_reg, out_dy_reg;
    logic [DIRZ_W-1:0] out_dz_reg;
    logic              out_clip_reg;
    logic [DIR_W-1:0]  dir_next [2];
    logic [DIRZ_W-1:0] dirz_next;
    logic [CQ_W-1:0]   qsat [3];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            if (cd_n_reg[a][CQ_W]) begin
                qsat[a] = (cd_ovf_reg[a][CQ_W] || cd_q_reg[a][CQ_W] > CQ_W'(32768))
                        ? CQ_W'(32768) : cd_q_reg[a][CQ_W];
                dir_next[a] = DIR_W'(CQ_W'(0) - qsat[a]);
            end else begin
                qsat[a] = (cd_ovf_reg[a][CQ_W] || cd_q_reg[a][CQ_W] > CQ_W'(32767))
                        ? CQ_W'(32767) : cd_q_reg[a][CQ_W];
                dir_next[a] = DIR_W'(qsat[a]);
            end
        end
        qsat[2] = (cd_ovf_reg[2][CQ_W] || cd_q_reg[2][CQ_W] > CQ_W'(32767))
                ? CQ_W'(32767) : cd_q_reg[2][CQ_W];
        dirz_next = DIRZ_W'(qsat[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            out_vld_reg <= cd_vld_reg[CQ_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            out_dx_reg   <= dir_next[0];
            out_dy_reg   <= dir_next[1];
            out_dz_reg   <= dirz_next;
            out_clip_reg <= cd_clip_reg[CQ_W];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_dz_reg, out_dy_reg, out_dx_reg};
    assign m_tuser  = out_clip_reg;

    // ---------------- checks ----------------
`include "pinhole_pixel_to_ray_assert.svh"
    // z component of a unit ray never vanishes (R is below 2^24)
    `PPR_ASSERT_IMPL(a_dirz_nonzero, out_vld_reg, out_dz_reg != '0)
    // the root of u^2 + v^2 + 1 is at least 1.0
    `PPR_ASSERT_IMPL(a_root_min, sq_vld_reg[ROOT_W], root_fin >= ROOT_W'(32'h1_0000))
    // a stall freezes the pipe
    `PPR_ASSERT_NEXT(a_stall_hold, !pipe_en, $stable(sum5_reg) && $stable(v5_reg))

endmodule
`default_nettype wire

>>> tb/sv/pinhole_pixel_to_ray_tb.sv
// Self-checking bench for pinhole_pixel_to_ray: drives pixel pairs and register writes,
// predicts each unit ray in fixed point and checks every result in order.
// Depends on ppr_pkg and the block's RTL.
`timescale 1ns / 1ps

class ray_scoreboard;
    bit [15:0] cx, cy, fx, fy;
    bit [15:0] want_x[$];
    bit [15:0] want_y[$];
    bit [14:0] want_z[$];
    bit        want_clip[$];
    int        errors;
    int        checked;

    function new();
        cx = 0; cy = 0; fx = 16; fy = 16;
        errors = 0; checked = 0;
    endfunction

    // offset in Q8.16 as sign and magnitude, with saturation
    function void offset(input bit [15:0] p, input bit [15:0] c, input bit [15:0] f,
                         output bit neg, output longint unsigned mag, inout bit clip);
        longint unsigned d, fd, q;
        fd = (f == 0) ? 1 : f;
        if (p >= c) begin
            d = p - c; neg = 0;
        end else begin
            d = c - p; neg = 1;
        end
        q = ((d << 16) + (fd >> 1)) / fd;
        if (neg && q > 64'd8388608) begin
            q = 64'd8388608; clip = 1;
        end else if (!neg && q > 64'd8388607) begin
            q = 64'd8388607; clip = 1;
        end
        if (q == 0) neg = 0;
        mag = q;
    endfunction

    function longint unsigned root(input longint unsigned s);
        longint unsigned r, b, v;
        r = 0; v = s; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function bit [15:0] comp(input bit neg, input longint unsigned mag,
                             input longint unsigned r);
        longint unsigned q;
        q = ((mag << 15) + (r >> 1)) / r;
        if (neg) begin
            if (q > 32768) q = 32768;
            return 16'(-q);
        end
        if (q > 32767) q = 32767;
        return 16'(q);
    endfunction

    function void note_pixel(input bit [15:0] px, input bit [15:0] py);
        bit nu, nv, clip;
        longint unsigned mu, mv, r, z;
        clip = 0;
        offset(px, cx, fx, nu, mu, clip);
        offset(py, cy, fy, nv, mv, clip);
        r = root(mu * mu + mv * mv + (64'd1 << 32));
        if (r == 0) r = 1;
        z = ((64'd1 << 31) + (r >> 1)) / r;
        if (z > 32767) z = 32767;
        want_x.insert(want_x.size(), comp(nu, mu, r));
        want_y.insert(want_y.size(), comp(nv, mv, r));
        want_z.insert(want_z.size(), 15'(z));
        want_clip.insert(want_clip.size(), clip);
    endfunction

    function void check_ray(input bit [47:0] data, input bit tuser);
        bit [15:0] ex, ey;
        bit [14:0] ez;
        bit        ec;
        if (want_x.size() == 0) begin
            $error("ray result with no pixel outstanding");
            errors++;
            return;
        end
        ex = want_x.pop_front(); ey = want_y.pop_front();
        ez = want_z.pop_front(); ec = want_clip.pop_front();
        checked++;
        if (data[15:0] !== ex) begin
            $error("dir_x expected %0d got %0d", $signed(ex), $signed(data[15:0])); errors++;
        end
        if (data[31:16] !== ey) begin
            $error("dir_y expected %0d got %0d", $signed(ey), $signed(data[31:16])); errors++;
        end
        if (data[46:32] !== ez) begin
            $error("dir_z expected %0d got %0d", ez, data[46:32]); errors++;
        end
        if (tuser !== ec) begin
            $error("clipped expected %0d got %0d", ec, tuser); errors++;
        end
    endfunction
endclass

module pinhole_pixel_to_ray_tb;
    import ppr_pkg::*;

    localparam int LATENCY  = 75;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1300;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;  // pixel_x [15:0], pixel_y [31:16]
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;       // dir_x [15:0], dir_y [31:16], dir_z [46:32], pad
    logic [0:0]  m_tuser;       // clipped
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    ray_scoreboard rays = new();
    int  idle_cycles = 0;
    bit  calm = 0;      // no idling in the final stretch
    int  pixels_sent = 0;

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    pinhole_pixel_to_ray i_dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    // result side: sample on the edge, stall in random bursts
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) rays.check_ray(m_tdata, m_tuser[0]);
            if (burst > 0 && !calm) begin
                burst--;
                m_tready <= 0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 18);
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // valid stays high across a run of writes; the caller drops it
    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_PRINCIPAL_X: rays.cx = val;
            REG_PRINCIPAL_Y: rays.cy = val;
            REG_FOCAL_X:     rays.fx = val;
            REG_FOCAL_Y:     rays.fy = val;
            default:         ;
        endcase
    endtask

    task automatic set_camera(input logic [15:0] px, input logic [15:0] py,
                              input logic [15:0] fxv, input logic [15:0] fyv);
        write_reg(REG_PRINCIPAL_X, px);
        write_reg(REG_PRINCIPAL_Y, py);
        write_reg(REG_FOCAL_X, fxv);
        write_reg(REG_FOCAL_Y, fyv);
        cfg_valid <= 0;
    endtask

    // one pixel pair; a random gap may come first
    task automatic send_pixel(input logic [15:0] px, input logic [15:0] py);
        if (!calm && $urandom_range(0, 11) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {py, px};
        do @(posedge aclk); while (!s_tready);
        rays.note_pixel(px, py);
        pixels_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (rays.want_x.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    // pixel near the principal point most of the time, anywhere otherwise
    function automatic logic [15:0] pick(input logic [15:0] centre);
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return centre + 16'($signed($urandom_range(0, 8191)) - 4096);
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: reset camera, extremes, saturation
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'h0010, 16'h0000);
        send_pixel(16'h0000, 16'h0010);
        drain();
        set_camera(16'h8000, 16'h8000, 16'h0000, 16'h0000); // zero focal acts as one sixteenth
        send_pixel(16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000);
        send_pixel(16'h8000, 16'h8000);
        send_pixel(16'h7FFF, 16'h8001);
        drain();
        set_camera(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'h0001, 16'hFFFE);
        drain();
        set_camera(16'h1400, 16'h0F00, 16'h2000, 16'h2000); // 320,240 ; f=512
        send_pixel(16'h2800, 16'h1E00);
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'h1400, 16'h0F00);
        send_pixel(16'hAAAA, 16'h5555);
        send_pixel(16'h5555, 16'hAAAA);
        drain();   // sender holds until all results are back

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_camera(16'h1400, 16'h0F00, 16'h1000, 16'h1000);
                1: set_camera(16'h0000, 16'hFFFF, 16'h0001, 16'h0002);
                2: set_camera(16'h8000, 16'h8000, 16'hFFFF, 16'h0010);
                default: set_camera(16'($urandom), 16'($urandom),
                                    16'($urandom_range(1, 65535)),
                                    16'($urandom_range(1, 65535)));
            endcase
            if (ph == 7) calm = 1;
            for (int k = 0; k < N_RANDOM / 8; k++)
                send_pixel(pick(rays.cx), pick(rays.cy));
            drain();
        end

        $display("Covered %0d pixel pairs over 12 camera settings, %0d rays checked.",
                 pixels_sent, rays.checked);
        if (rays.errors == 0 && rays.want_x.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
